// ===== hdl/ocab_pkg.sv =====
// Shared types, constants and saturating arithmetic helpers for the
// closest approach bisection unit. No dependencies.
`default_nettype none
package ocab_pkg;

   // width of degree, coefficient index and derivative factor fields
   localparam int K_BITS = 4;

   localparam logic signed [63:0] FIVE_Q32  = 64'sd21474836480;
   localparam logic        [63:0] COS_SCALE = 64'd100000000000;
   localparam logic signed [63:0] S64_MAX   = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN   = {1'b1, {63{1'b0}}};

   // input word operation codes
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_SOLVE = 1'b1;

   // configuration register indexes
   localparam logic [2:0] REG_DEGREE     = 3'd0;
   localparam logic [2:0] REG_MAX_ITERS  = 3'd1;
   localparam logic [2:0] REG_MEAN_TIME  = 3'd2;
   localparam logic [2:0] REG_MEAN_X     = 3'd3;
   localparam logic [2:0] REG_MEAN_Y     = 3'd4;
   localparam logic [2:0] REG_MEAN_Z     = 3'd5;
   localparam logic [2:0] REG_START_TIME = 3'd6;
   localparam logic [2:0] REG_STOP_TIME  = 3'd7;

   // register updates of the datapath
   typedef enum logic [4:0] {
      OP_NONE, OP_INIT, OP_T_LO, OP_T_MID, OP_TC, OP_PINIT, OP_PADD, OP_POS,
      OP_DL, OP_VINIT, OP_VADD, OP_VEL, OP_ZERO, OP_SHR_VEL, OP_SHR_DL,
      OP_SHR_STEP, OP_SAVE_A, OP_SAVE_B, OP_SQ_CLR, OP_ACC_D, OP_ACC_NA,
      OP_ACC_NB, OP_SAVE_NA, OP_SAVE_NB, OP_SAVE_BIG, OP_HIT, OP_SGNLO,
      OP_BRACKET, OP_MID, OP_OUT
   } dp_op_type;

   // multiplier operand pairs
   typedef enum logic [2:0] {
      MS_ACC_TC, MS_A_B, MS_A_A, MS_B_B, MS_D_SCALE, MS_NA_NB
   } msel_type;

   // purpose of the evaluation in progress
   typedef enum logic [1:0] {EV_FIRST, EV_LOOP, EV_FINAL} ev_type;

   typedef struct packed {
      dp_op_type           op;
      logic                rd;
      logic                mul_go;
      msel_type            msel;
      logic                sqrt_go;
      logic                sqrt_sel;
      logic                load_we;
      logic [1:0]          axis;
      logic [K_BITS-1:0]   k;
      logic [K_BITS-1:0]   fac;
      logic [1:0]          idx;
      logic [9:0]          itr;
      logic                conv;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic sqrt_busy;
      logic sh_ok;
      logic zero_vec;
      logic hit;
   } dp_stat_type;

   typedef struct packed {
      logic signed [63:0] mean_time;
      logic signed [63:0] mean_x;
      logic signed [63:0] mean_y;
      logic signed [63:0] mean_z;
      logic signed [63:0] start_time;
      logic signed [63:0] stop_time;
   } dp_cfg_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

   // floor((a + b) / 2)
   function automatic logic signed [63:0] mid_of(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      return s[64:1];
   endfunction

   // floor(+-p / 2^32) saturated, p a 128-bit magnitude
   function automatic logic signed [63:0] q32_of(input logic [127:0] p,
                                                 input logic neg);
      logic [63:0] q;
      logic [63:0] m;
      q = p[95:32];
      m = q + {63'd0, |p[31:0]};
      if (|p[127:96]) return neg ? S64_MIN : S64_MAX;
      if (!neg) return q[63] ? S64_MAX : q;
      if (q[63] || m[63]) return S64_MIN;
      return -m;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/ocab_mul.sv =====
// Sequential 64x64 magnitude multiplier built on one 32x32 product per cycle.
// Depends on nothing; used by the datapath.
`default_nettype none
module ocab_mul (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               go,
   input  wire logic signed [63:0] a,
   input  wire logic signed [63:0] b,
   output logic                    busy,
   output logic [127:0]            prod,
   output logic                    neg
);
   logic [63:0]  ma_ff, mb_ff, pp_ff;
   logic [127:0] acc_ff;
   logic         neg_ff, run_ff, pv_ff;
   logic [2:0]   cnt_ff;
   logic [1:0]   psh_ff;
   logic [31:0]  ha, hb;

   // partial product halves chosen by step count
   assign ha = cnt_ff[0] ? ma_ff[63:32] : ma_ff[31:0];
   assign hb = cnt_ff[1] ? mb_ff[63:32] : mb_ff[31:0];

   // sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         pv_ff  <= 1'b0;
         cnt_ff <= '0;
      end else if (go) begin
         run_ff <= 1'b1;
         pv_ff  <= 1'b0;
         cnt_ff <= '0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + 3'd1;
         pv_ff  <= (cnt_ff < 3'd4);
         if (cnt_ff == 3'd4) run_ff <= 1'b0;
      end
   end

   // operands, partial product and accumulation
   always_ff @(posedge clock) begin
      if (go) begin
         ma_ff  <= a[63] ? (~a + 64'd1) : a;
         mb_ff  <= b[63] ? (~b + 64'd1) : b;
         neg_ff <= a[63] ^ b[63];
         acc_ff <= '0;
      end else if (run_ff) begin
         if (cnt_ff < 3'd4) begin
            pp_ff  <= ha * hb;
            psh_ff <= {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
         end
         if (pv_ff) acc_ff <= acc_ff + ({64'd0, pp_ff} << {psh_ff, 5'd0});
      end
   end

   assign busy = run_ff;
   assign prod = acc_ff;
   assign neg  = neg_ff;
endmodule
`default_nettype wire

// ===== hdl/ocab_sqrt.sv =====
// Bit-serial integer square root: each step takes two radicand bits, one root bit.
// Depends on nothing; used by the datapath.
`default_nettype none
module ocab_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        go,
   input  wire logic [63:0] n_in,
   output logic             busy,
   output logic [31:0]      root
);
   logic [63:0] n_ff, res_ff, bit_ff, trial;

   assign trial = res_ff + bit_ff;

   // control: the scan bit doubles as the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else if (go) begin
         bit_ff <= 64'd1 << 62;
      end else if (bit_ff != 64'd0) begin
         bit_ff <= bit_ff >> 2;
      end
   end

   // remainder and root
   always_ff @(posedge clock) begin
      if (go) begin
         n_ff   <= n_in;
         res_ff <= '0;
      end else if (bit_ff != 64'd0) begin
         if (n_ff >= trial) begin
            n_ff   <= n_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
      end
   end

   assign busy = (bit_ff != 64'd0);
   assign root = res_ff[31:0];
endmodule
`default_nettype wire

// ===== hdl/ocab_dp.sv =====
// Datapath: coefficient memory, polynomial, vector, cosine and bracket registers.
// Depends on ocab_pkg, ocab_mul and ocab_sqrt.
`default_nettype none
module ocab_dp #(
   parameter int MAX_DEGREE = 7
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ocab_pkg::dp_cmd_type cmd,
   input  wire ocab_pkg::dp_cfg_type cfg,
   output ocab_pkg::dp_stat_type    stat,
   input  wire logic [1:0]          req_axis,
   input  wire logic [2:0]          req_coeff_index,
   input  wire logic signed [63:0]  req_coeff_value,
   input  wire logic signed [63:0]  req_station_x,
   input  wire logic signed [63:0]  req_station_y,
   input  wire logic signed [63:0]  req_station_z,
   output logic                     rsp_valid,
   output logic signed [63:0]       rsp_sat_x,
   output logic signed [63:0]       rsp_sat_y,
   output logic signed [63:0]       rsp_sat_z,
   output logic signed [63:0]       rsp_approach_time,
   output logic [9:0]               rsp_iterations_used,
   output logic                     rsp_converged
);
   import ocab_pkg::*;

   localparam int NCOEF = MAX_DEGREE + 1;
   localparam int DEPTH = 3 * NCOEF;
   localparam int AW    = $clog2(DEPTH);

   logic signed [63:0] coef_mem [DEPTH];
   logic signed [63:0] coef_rd_ff, cs, fac_term;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               wr_ok;

   logic signed [63:0] lo_ff, hi_ff, mid_ff, t_ff, tc_ff, acc_ff, dot_ff;
   logic signed [63:0] stn_ff [3];
   logic signed [63:0] pos_ff [3];
   logic signed [63:0] vel_ff [3];
   logic signed [63:0] dl_ff  [3];
   logic signed [63:0] sh_ff  [3];
   logic signed [30:0] a_ff   [3];
   logic signed [30:0] b_ff   [3];
   logic [63:0]        na2_ff, nb2_ff, sp;
   logic [31:0]        na_ff, nb_ff;
   logic [127:0]       big_ff;
   logic               sgn_pos_ff, sgn_neg_ff, lo_pos_ff, lo_neg_ff, hit_ff;
   logic signed [63:0] mean_sel;
   logic               rsp_valid_ff;

   logic signed [63:0] mul_a, mul_b, q32;
   logic [127:0]       mul_prod;
   logic               mul_busy, mul_neg, sqrt_busy;
   logic [31:0]        sqrt_root;

   // coefficient memory: written by loads, read one word at a time
   assign wr_ok   = (req_axis != 2'd3) && (32'(req_coeff_index) <= MAX_DEGREE);
   assign wr_addr = AW'(32'(req_axis) * NCOEF + 32'(req_coeff_index));
   assign rd_addr = AW'(32'(cmd.axis) * NCOEF + 32'(cmd.k));

   always_ff @(posedge clock) begin
      if (cmd.load_we && wr_ok) coef_mem[wr_addr] <= req_coeff_value;
      if (cmd.rd) coef_rd_ff <= coef_mem[rd_addr];
   end

   assign cs       = coef_rd_ff >>> 16;
   assign fac_term = 64'(cs * $signed({1'b0, cmd.fac}));

   // multiplier operand select
   always_comb begin
      unique case (cmd.msel)
         MS_ACC_TC: begin
            mul_a = acc_ff;
            mul_b = tc_ff;
         end
         MS_A_B: begin
            mul_a = 64'(a_ff[cmd.idx]);
            mul_b = 64'(b_ff[cmd.idx]);
         end
         MS_A_A: begin
            mul_a = 64'(a_ff[cmd.idx]);
            mul_b = 64'(a_ff[cmd.idx]);
         end
         MS_B_B: begin
            mul_a = 64'(b_ff[cmd.idx]);
            mul_b = 64'(b_ff[cmd.idx]);
         end
         MS_D_SCALE: begin
            mul_a = dot_ff;
            mul_b = COS_SCALE;
         end
         MS_NA_NB: begin
            mul_a = {32'd0, na_ff};
            mul_b = {32'd0, nb_ff};
         end
         default: begin
            mul_a = acc_ff;
            mul_b = tc_ff;
         end
      endcase
   end

   ocab_mul u_mul (
      .clock (clock),
      .reset (reset),
      .go    (cmd.mul_go),
      .a     (mul_a),
      .b     (mul_b),
      .busy  (mul_busy),
      .prod  (mul_prod),
      .neg   (mul_neg)
   );

   ocab_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .go    (cmd.sqrt_go),
      .n_in  (cmd.sqrt_sel ? nb2_ff : na2_ff),
      .busy  (sqrt_busy),
      .root  (sqrt_root)
   );

   assign q32 = q32_of(mul_prod, mul_neg);
   assign sp  = mul_neg ? (~mul_prod[63:0] + 64'd1) : mul_prod[63:0];

   always_comb begin
      unique case (cmd.axis)
         2'd0:    mean_sel = cfg.mean_x;
         2'd1:    mean_sel = cfg.mean_y;
         default: mean_sel = cfg.mean_z;
      endcase
   end

   // register updates, one operation per cycle
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_INIT: begin
            lo_ff     <= sat_sub(cfg.start_time, FIVE_Q32);
            hi_ff     <= sat_add(cfg.stop_time, FIVE_Q32);
            stn_ff[0] <= req_station_x;
            stn_ff[1] <= req_station_y;
            stn_ff[2] <= req_station_z;
         end
         OP_T_LO:  t_ff <= lo_ff;
         OP_T_MID: t_ff <= mid_ff;
         OP_TC:    tc_ff <= sat_sub(t_ff, cfg.mean_time);
         OP_PINIT: acc_ff <= cs;
         OP_PADD:  acc_ff <= sat_add(q32, cs);
         OP_POS:   pos_ff[cmd.axis] <= sat_add(acc_ff, mean_sel);
         OP_DL:    dl_ff[cmd.axis] <= sat_sub(pos_ff[cmd.axis], stn_ff[cmd.axis]);
         OP_VINIT: acc_ff <= fac_term;
         OP_VADD:  acc_ff <= sat_add(q32, fac_term);
         OP_VEL:   vel_ff[cmd.axis] <= acc_ff;
         OP_ZERO: begin
            sgn_pos_ff <= 1'b0;
            sgn_neg_ff <= 1'b0;
            hit_ff     <= 1'b1;
         end
         OP_SHR_VEL: sh_ff <= vel_ff;
         OP_SHR_DL:  sh_ff <= dl_ff;
         OP_SHR_STEP: begin
            for (int i = 0; i < 3; i++) sh_ff[i] <= sh_ff[i] >>> 1;
         end
         OP_SAVE_A: begin
            for (int i = 0; i < 3; i++) a_ff[i] <= sh_ff[i][30:0];
         end
         OP_SAVE_B: begin
            for (int i = 0; i < 3; i++) b_ff[i] <= sh_ff[i][30:0];
         end
         OP_SQ_CLR: begin
            dot_ff <= '0;
            na2_ff <= '0;
            nb2_ff <= '0;
         end
         OP_ACC_D:    dot_ff <= dot_ff + $signed(sp);
         OP_ACC_NA:   na2_ff <= na2_ff + sp;
         OP_ACC_NB:   nb2_ff <= nb2_ff + sp;
         OP_SAVE_NA:  na_ff <= sqrt_root;
         OP_SAVE_NB:  nb_ff <= sqrt_root;
         OP_SAVE_BIG: big_ff <= mul_prod;
         OP_HIT: begin
            hit_ff     <= (big_ff <= mul_prod);
            sgn_pos_ff <= !dot_ff[63] && (dot_ff != 64'sd0);
            sgn_neg_ff <= dot_ff[63];
         end
         OP_SGNLO: begin
            lo_pos_ff <= sgn_pos_ff;
            lo_neg_ff <= sgn_neg_ff;
         end
         OP_BRACKET: begin
            // same nonzero sign at both ends: move the low end
            if ((lo_pos_ff && sgn_pos_ff) || (lo_neg_ff && sgn_neg_ff)) begin
               lo_ff     <= mid_ff;
               lo_pos_ff <= sgn_pos_ff;
               lo_neg_ff <= sgn_neg_ff;
            end else begin
               hi_ff <= mid_ff;
            end
         end
         OP_MID: mid_ff <= mid_of(lo_ff, hi_ff);
         OP_OUT: begin
            rsp_sat_x           <= pos_ff[0];
            rsp_sat_y           <= pos_ff[1];
            rsp_sat_z           <= pos_ff[2];
            rsp_approach_time   <= mid_ff;
            rsp_iterations_used <= cmd.itr;
            rsp_converged       <= cmd.conv;
         end
         default: ;
      endcase
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= (cmd.op == OP_OUT);
   end
   assign rsp_valid = rsp_valid_ff;

   // status back to the controller
   always_comb begin
      stat.mul_busy  = mul_busy;
      stat.sqrt_busy = sqrt_busy;
      stat.sh_ok     = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (!((&sh_ff[i][63:30]) || !(|sh_ff[i][63:30]))) stat.sh_ok = 1'b0;
      end
      stat.zero_vec = (vel_ff[0] == 64'sd0 && vel_ff[1] == 64'sd0 && vel_ff[2] == 64'sd0)
                   || (dl_ff[0] == 64'sd0 && dl_ff[1] == 64'sd0 && dl_ff[2] == 64'sd0);
      stat.hit      = hit_ff;
   end
endmodule
`default_nettype wire

// ===== hdl/ocab_ctrl.sv =====
// Controller: sequences evaluations, the vector steps and the bisection loop.
// Depends on ocab_pkg; drives the datapath through dp_cmd_type.
`default_nettype none
module ocab_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          req_op,
   input  wire logic [ocab_pkg::K_BITS-1:0]   deg,
   input  wire logic [9:0]                    iter_limit,
   input  wire ocab_pkg::dp_stat_type         stat,
   output ocab_pkg::dp_cmd_type               cmd,
   output logic                               busy
);
   import ocab_pkg::*;

   typedef enum logic [36:0] {
      S_IDLE  = 37'd1 << 0,  S_TLO   = 37'd1 << 1,  S_TC    = 37'd1 << 2,
      S_PRD0  = 37'd1 << 3,  S_PINIT = 37'd1 << 4,  S_PMUL  = 37'd1 << 5,
      S_PWAIT = 37'd1 << 6,  S_POS   = 37'd1 << 7,  S_DL    = 37'd1 << 8,
      S_VRD0  = 37'd1 << 9,  S_VINIT = 37'd1 << 10, S_VMUL  = 37'd1 << 11,
      S_VWAIT = 37'd1 << 12, S_VEL   = 37'd1 << 13, S_ZCHK  = 37'd1 << 14,
      S_SHA   = 37'd1 << 15, S_SHBL  = 37'd1 << 16, S_SHB   = 37'd1 << 17,
      S_SQCLR = 37'd1 << 18, S_DMUL  = 37'd1 << 19, S_DWAIT = 37'd1 << 20,
      S_AMUL  = 37'd1 << 21, S_AWAIT = 37'd1 << 22, S_BMUL  = 37'd1 << 23,
      S_BWAIT = 37'd1 << 24, S_SQA   = 37'd1 << 25, S_SQAW  = 37'd1 << 26,
      S_SQB   = 37'd1 << 27, S_SQBW  = 37'd1 << 28, S_HMUL1 = 37'd1 << 29,
      S_HW1   = 37'd1 << 30, S_HMUL2 = 37'd1 << 31, S_HW2   = 37'd1 << 32,
      S_EVDN  = 37'd1 << 33, S_MID0  = 37'd1 << 34, S_LOOP  = 37'd1 << 35,
      S_TMID  = 37'd1 << 36
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        ax_ff, ax_in, i_ff, i_in;
   logic [K_BITS-1:0] k_ff, k_in;
   logic [9:0]        itr_ff, itr_in;
   logic              conv_ff, conv_in;
   ev_type            ev_ff, ev_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ax_ff    <= '0;
         i_ff     <= '0;
         k_ff     <= '0;
         itr_ff   <= '0;
         conv_ff  <= 1'b0;
         ev_ff    <= EV_FIRST;
      end else begin
         state_ff <= state_in;
         ax_ff    <= ax_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
         itr_ff   <= itr_in;
         conv_ff  <= conv_in;
         ev_ff    <= ev_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ax_in    = ax_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      itr_in   = itr_ff;
      conv_in  = conv_ff;
      ev_in    = ev_ff;
      cmd      = '0;
      cmd.axis = ax_ff;
      cmd.k    = k_ff;
      cmd.fac  = deg - k_ff;
      cmd.idx  = i_ff;
      cmd.itr  = itr_ff;
      cmd.conv = conv_ff;

      unique case (state_ff)
         // take a word: loads finish here, solves start the search
         S_IDLE: begin
            if (start) begin
               if (req_op == REQ_SOLVE) begin
                  cmd.op   = OP_INIT;
                  itr_in   = '0;
                  conv_in  = 1'b0;
                  state_in = S_TLO;
               end else begin
                  cmd.load_we = 1'b1;
               end
            end
         end
         S_TLO: begin
            cmd.op   = OP_T_LO;
            ev_in    = EV_FIRST;
            state_in = S_TC;
         end
         S_TC: begin
            cmd.op   = OP_TC;
            ax_in    = '0;
            state_in = S_PRD0;
         end
         // position by Horner's rule
         S_PRD0: begin
            cmd.rd   = 1'b1;
            cmd.k    = '0;
            state_in = S_PINIT;
         end
         S_PINIT: begin
            cmd.op   = OP_PINIT;
            k_in     = K_BITS'(1);
            state_in = (deg == '0) ? S_POS : S_PMUL;
         end
         S_PMUL: begin
            cmd.rd     = 1'b1;
            cmd.mul_go = 1'b1;
            cmd.msel   = MS_ACC_TC;
            state_in   = S_PWAIT;
         end
         S_PWAIT: begin
            if (!stat.mul_busy) begin
               cmd.op = OP_PADD;
               if (k_ff == deg) begin
                  state_in = S_POS;
               end else begin
                  k_in     = k_ff + K_BITS'(1);
                  state_in = S_PMUL;
               end
            end
         end
         S_POS: begin
            cmd.op   = OP_POS;
            state_in = S_DL;
         end
         S_DL: begin
            cmd.op   = OP_DL;
            state_in = S_VRD0;
         end
         // velocity as the derivative polynomial
         S_VRD0: begin
            cmd.rd   = 1'b1;
            cmd.k    = '0;
            state_in = S_VINIT;
         end
         S_VINIT: begin
            cmd.op   = OP_VINIT;
            cmd.fac  = deg;
            k_in     = K_BITS'(1);
            state_in = (deg <= K_BITS'(1)) ? S_VEL : S_VMUL;
         end
         S_VMUL: begin
            cmd.rd     = 1'b1;
            cmd.mul_go = 1'b1;
            cmd.msel   = MS_ACC_TC;
            state_in   = S_VWAIT;
         end
         S_VWAIT: begin
            if (!stat.mul_busy) begin
               cmd.op = OP_VADD;
               if (k_ff == deg - K_BITS'(1)) begin
                  state_in = S_VEL;
               end else begin
                  k_in     = k_ff + K_BITS'(1);
                  state_in = S_VMUL;
               end
            end
         end
         S_VEL: begin
            cmd.op = OP_VEL;
            if (ax_ff == 2'd2) begin
               state_in = S_ZCHK;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_PRD0;
            end
         end
         // zero vectors count as met, else scale both vectors
         S_ZCHK: begin
            if (stat.zero_vec) begin
               cmd.op   = OP_ZERO;
               state_in = S_EVDN;
            end else begin
               cmd.op   = OP_SHR_VEL;
               state_in = S_SHA;
            end
         end
         S_SHA: begin
            if (stat.sh_ok) begin
               cmd.op   = OP_SAVE_A;
               state_in = S_SHBL;
            end else begin
               cmd.op = OP_SHR_STEP;
            end
         end
         S_SHBL: begin
            cmd.op   = OP_SHR_DL;
            state_in = S_SHB;
         end
         S_SHB: begin
            if (stat.sh_ok) begin
               cmd.op   = OP_SAVE_B;
               state_in = S_SQCLR;
            end else begin
               cmd.op = OP_SHR_STEP;
            end
         end
         // dot product and squared norms, one component at a time
         S_SQCLR: begin
            cmd.op   = OP_SQ_CLR;
            i_in     = '0;
            state_in = S_DMUL;
         end
         S_DMUL: begin
            cmd.mul_go = 1'b1;
            cmd.msel   = MS_A_B;
            state_in   = S_DWAIT;
         end
         S_DWAIT: begin
            if (!stat.mul_busy) begin
               cmd.op   = OP_ACC_D;
               state_in = S_AMUL;
            end
         end
         S_AMUL: begin
            cmd.mul_go = 1'b1;
            cmd.msel   = MS_A_A;
            state_in   = S_AWAIT;
         end
         S_AWAIT: begin
            if (!stat.mul_busy) begin
               cmd.op   = OP_ACC_NA;
               state_in = S_BMUL;
            end
         end
         S_BMUL: begin
            cmd.mul_go = 1'b1;
            cmd.msel   = MS_B_B;
            state_in   = S_BWAIT;
         end
         S_BWAIT: begin
            if (!stat.mul_busy) begin
               cmd.op = OP_ACC_NB;
               if (i_ff == 2'd2) begin
                  state_in = S_SQA;
               end else begin
                  i_in     = i_ff + 2'd1;
                  state_in = S_DMUL;
               end
            end
         end
         // norms
         S_SQA: begin
            cmd.sqrt_go  = 1'b1;
            cmd.sqrt_sel = 1'b0;
            state_in     = S_SQAW;
         end
         S_SQAW: begin
            if (!stat.sqrt_busy) begin
               cmd.op   = OP_SAVE_NA;
               state_in = S_SQB;
            end
         end
         S_SQB: begin
            cmd.sqrt_go  = 1'b1;
            cmd.sqrt_sel = 1'b1;
            state_in     = S_SQBW;
         end
         S_SQBW: begin
            if (!stat.sqrt_busy) begin
               cmd.op   = OP_SAVE_NB;
               state_in = S_HMUL1;
            end
         end
         // cosine threshold: |D| * 1e11 against na * nb
         S_HMUL1: begin
            cmd.mul_go = 1'b1;
            cmd.msel   = MS_D_SCALE;
            state_in   = S_HW1;
         end
         S_HW1: begin
            if (!stat.mul_busy) begin
               cmd.op   = OP_SAVE_BIG;
               state_in = S_HMUL2;
            end
         end
         S_HMUL2: begin
            cmd.mul_go = 1'b1;
            cmd.msel   = MS_NA_NB;
            state_in   = S_HW2;
         end
         S_HW2: begin
            if (!stat.mul_busy) begin
               cmd.op   = OP_HIT;
               state_in = S_EVDN;
            end
         end
         // evaluation finished: act on its purpose
         S_EVDN: begin
            unique case (ev_ff)
               EV_FIRST: begin
                  cmd.op   = OP_SGNLO;
                  state_in = S_MID0;
               end
               EV_LOOP: begin
                  cmd.op   = OP_BRACKET;
                  conv_in  = stat.hit;
                  itr_in   = itr_ff + 10'd1;
                  state_in = S_LOOP;
               end
               default: begin
                  cmd.op   = OP_OUT;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_MID0: begin
            cmd.op   = OP_MID;
            state_in = S_LOOP;
         end
         S_LOOP: begin
            if (!conv_ff && (itr_ff < iter_limit)) begin
               cmd.op = OP_MID;
               ev_in  = EV_LOOP;
            end else begin
               ev_in  = EV_FINAL;
            end
            state_in = S_TMID;
         end
         S_TMID: begin
            cmd.op   = OP_T_MID;
            state_in = S_TC;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
endmodule
`default_nettype wire

// ===== hdl/orbit_closest_approach_bisection_unit.sv =====
// Closest approach bisection unit. A load word is written while idle; a solve runs
// (iterations + 2) evaluations. One solve at a time; the receiver cannot stall.
// Synchronous reset restores config defaults; coefficient memory is not cleared.
`default_nettype none
module orbit_closest_approach_bisection_unit #(
   parameter int MAX_DEGREE = 7
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_op,
   input  wire logic [1:0]         req_axis,
   input  wire logic [2:0]         req_coeff_index,
   input  wire logic signed [63:0] req_coeff_value,
   input  wire logic signed [63:0] req_station_x,
   input  wire logic signed [63:0] req_station_y,
   input  wire logic signed [63:0] req_station_z,
   output logic                    rsp_valid,
   output logic signed [63:0]      rsp_sat_x,
   output logic signed [63:0]      rsp_sat_y,
   output logic signed [63:0]      rsp_sat_z,
   output logic signed [63:0]      rsp_approach_time,
   output logic [9:0]              rsp_iterations_used,
   output logic                    rsp_converged,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [5:0]         paddr,
   input  wire logic [63:0]        pwdata,
   output logic [63:0]             prdata,
   output logic                    pready
);
   import ocab_pkg::*;

   logic [2:0]        degree_ff;
   logic [9:0]        maxit_ff;
   dp_cfg_type        cfg_ff;
   logic              wr_en;
   logic [2:0]        reg_idx;
   logic [K_BITS-1:0] deg_eff;
   dp_cmd_type        cmd;
   dp_stat_type       stat;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[5:3];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= 3'd1;
         maxit_ff  <= 10'd1000;
         cfg_ff    <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_DEGREE:     degree_ff         <= pwdata[2:0];
            REG_MAX_ITERS:  maxit_ff          <= pwdata[9:0];
            REG_MEAN_TIME:  cfg_ff.mean_time  <= pwdata;
            REG_MEAN_X:     cfg_ff.mean_x     <= pwdata;
            REG_MEAN_Y:     cfg_ff.mean_y     <= pwdata;
            REG_MEAN_Z:     cfg_ff.mean_z     <= pwdata;
            REG_START_TIME: cfg_ff.start_time <= pwdata;
            REG_STOP_TIME:  cfg_ff.stop_time  <= pwdata;
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (reg_idx)
         REG_DEGREE:     prdata = {61'd0, degree_ff};
         REG_MAX_ITERS:  prdata = {54'd0, maxit_ff};
         REG_MEAN_TIME:  prdata = cfg_ff.mean_time;
         REG_MEAN_X:     prdata = cfg_ff.mean_x;
         REG_MEAN_Y:     prdata = cfg_ff.mean_y;
         REG_MEAN_Z:     prdata = cfg_ff.mean_z;
         REG_START_TIME: prdata = cfg_ff.start_time;
         REG_STOP_TIME:  prdata = cfg_ff.stop_time;
         default:        prdata = '0;
      endcase
   end

   // degree clamped to what the memory holds
   assign deg_eff = (32'(degree_ff) > MAX_DEGREE) ? K_BITS'(MAX_DEGREE)
                                                  : K_BITS'(degree_ff);

   ocab_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_op     (req_op),
      .deg        (deg_eff),
      .iter_limit (maxit_ff),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   ocab_dp #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .cfg                 (cfg_ff),
      .stat                (stat),
      .req_axis            (req_axis),
      .req_coeff_index     (req_coeff_index),
      .req_coeff_value     (req_coeff_value),
      .req_station_x       (req_station_x),
      .req_station_y       (req_station_y),
      .req_station_z       (req_station_z),
      .rsp_valid           (rsp_valid),
      .rsp_sat_x           (rsp_sat_x),
      .rsp_sat_y           (rsp_sat_y),
      .rsp_sat_z           (rsp_sat_z),
      .rsp_approach_time   (rsp_approach_time),
      .rsp_iterations_used (rsp_iterations_used),
      .rsp_converged       (rsp_converged)
   );
endmodule
`default_nettype wire
